[sv/b32ts_pkg.sv]
package b32ts_pkg;

	localparam int WIN_LEN       = 15;
	localparam int BODY_LEN      = 12;
	localparam int FILL_W        = $clog2(WIN_LEN + 1);
	localparam int PAY_W         = 52;
	localparam int TOKEN_W       = 47;
	localparam int MIN_W         = 17;
	localparam int SUFFIX_DIGITS = 5;
	localparam int DCNT_W        = 3;
	localparam int CHK_BYTES     = 7;
	localparam int CHK_CNT_W     = 3;

	localparam logic [7:0] CHK_INIT  = 8'hC5;
	localparam logic [7:0] CHK_PRIME = 8'h93;

	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_N    = 8'h4E;
	localparam logic [7:0] CH_E    = 8'h45;
	localparam logic [7:0] CH_ONE  = 8'h31;

	typedef struct packed {
		logic             cand;     // window full, starts with NE1, body all base32
		logic [PAY_W-1:0] payload;
		logic [7:0]       chk;
	} win_status_t;

	// {ok, value}
	function automatic logic [5:0] digit_decode(input logic [7:0] c);
		logic [5:0] r;
		unique case (c)
			8'h30, 8'h4F:         r = {1'b1, 5'd0};
			8'h31, 8'h49, 8'h4C:  r = {1'b1, 5'd1};
			8'h32: r = {1'b1, 5'd2};
			8'h33: r = {1'b1, 5'd3};
			8'h34: r = {1'b1, 5'd4};
			8'h35: r = {1'b1, 5'd5};
			8'h36: r = {1'b1, 5'd6};
			8'h37: r = {1'b1, 5'd7};
			8'h38: r = {1'b1, 5'd8};
			8'h39: r = {1'b1, 5'd9};
			8'h41: r = {1'b1, 5'd10};
			8'h42: r = {1'b1, 5'd11};
			8'h43: r = {1'b1, 5'd12};
			8'h44: r = {1'b1, 5'd13};
			8'h45: r = {1'b1, 5'd14};
			8'h46: r = {1'b1, 5'd15};
			8'h47: r = {1'b1, 5'd16};
			8'h48: r = {1'b1, 5'd17};
			8'h4A: r = {1'b1, 5'd18};
			8'h4B: r = {1'b1, 5'd19};
			8'h4D: r = {1'b1, 5'd20};
			8'h4E: r = {1'b1, 5'd21};
			8'h50: r = {1'b1, 5'd22};
			8'h51: r = {1'b1, 5'd23};
			8'h52: r = {1'b1, 5'd24};
			8'h53: r = {1'b1, 5'd25};
			8'h54: r = {1'b1, 5'd26};
			8'h56: r = {1'b1, 5'd27};
			8'h57: r = {1'b1, 5'd28};
			8'h58: r = {1'b1, 5'd29};
			8'h59: r = {1'b1, 5'd30};
			8'h5A: r = {1'b1, 5'd31};
			default: r = 6'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

	function automatic logic is_kept(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) || c == CH_PLUS;
	endfunction

endpackage

[sv/b32ts_window.sv]
module b32ts_window (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  logic                     clr,
	input  logic [7:0]               ch,
	output b32ts_pkg::win_status_t   status
);

	logic [7:0]                    win_q [b32ts_pkg::WIN_LEN];
	logic [b32ts_pkg::FILL_W-1:0]  fill_q;
	logic [5*b32ts_pkg::BODY_LEN-1:0] full_val;
	logic                          body_ok;
	logic [5:0]                    dec [b32ts_pkg::BODY_LEN];

	// entries are only looked at once all of them have been written
	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < b32ts_pkg::WIN_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[b32ts_pkg::WIN_LEN-1] <= ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (clr) begin
			fill_q <= '0;
		end else if (push && fill_q != b32ts_pkg::FILL_W'(b32ts_pkg::WIN_LEN)) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_comb begin
		body_ok  = 1'b1;
		full_val = '0;
		for (int i = 0; i < b32ts_pkg::BODY_LEN; i++) begin
			dec[i]  = b32ts_pkg::digit_decode(win_q[3+i]);
			body_ok = body_ok & dec[i][5];
			full_val[5*(b32ts_pkg::BODY_LEN-1-i) +: 5] = dec[i][4:0];
		end
	end

	assign status.cand = (fill_q == b32ts_pkg::FILL_W'(b32ts_pkg::WIN_LEN)) && body_ok
		&& win_q[0] == b32ts_pkg::CH_N && win_q[1] == b32ts_pkg::CH_E
		&& win_q[2] == b32ts_pkg::CH_ONE;
	assign status.payload = full_val[5*b32ts_pkg::BODY_LEN-1 -: b32ts_pkg::PAY_W];
	assign status.chk     = full_val[7:0];

endmodule

[sv/b32ts_check.sv]
module b32ts_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [b32ts_pkg::PAY_W-1:0]   payload,
	output logic                          done,
	output logic [7:0]                    acc
);

	localparam int SH_W = 8 * b32ts_pkg::CHK_BYTES;

	logic [SH_W-1:0]                 sh_q;
	logic [7:0]                      acc_q;
	logic [b32ts_pkg::CHK_CNT_W-1:0] cnt_q;
	logic [15:0]                     prod;

	// low byte of FNV-1a, one payload byte per cycle, top byte first
	assign prod = 16'(acc_q ^ sh_q[SH_W-1 -: 8]) * 16'(b32ts_pkg::CHK_PRIME);

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= {{(SH_W - b32ts_pkg::PAY_W){1'b0}}, payload};
			acc_q <= b32ts_pkg::CHK_INIT;
		end else if (cnt_q != '0) begin
			sh_q  <= {sh_q[SH_W-9:0], 8'd0};
			acc_q <= prod[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= b32ts_pkg::CHK_CNT_W'(b32ts_pkg::CHK_BYTES);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign done = (cnt_q == b32ts_pkg::CHK_CNT_W'(1));
	assign acc  = prod[7:0];

endmodule

[sv/base32_token_scan_decoder.sv]
// Scans text for a base32 token "NE1" + 12 digits with a check byte, plus an
// optional "+minutes" suffix.
// Input channel: one byte per request (character, last). Output channel: one
// request per string, sent after the byte marked last: found, seed, mood,
// x_code, y_code, minutes (all zero when nothing was found).
// cfg_we/cfg_wdata write mood_limit (reset 6); write only while idle.
// A byte that is dropped, or arrives after the token, does not stall the
// input. A kept byte during the search stalls it for the window shift, then
// the candidate test; when the window holds a candidate the checksum unit
// then hashes the 7 payload bytes, one at a time. A byte marked last holds
// the input while the result is loaded, longer if the previous result is
// still stalled in the output register.
// The result is offered from the output register after the emit state.
// The receiver may stall the result indefinitely; the next string is taken
// in meanwhile, and only its own result waits for the output register.
// Reset clears the scan state and out_valid; mood_limit returns to 6.
module base32_token_scan_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  character,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [31:0] seed,
	output logic [2:0]  mood,
	output logic [5:0]  x_code,
	output logic [5:0]  y_code,
	output logic [16:0] minutes,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LOAD  = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	localparam logic [1:0] PH_SEARCH = 2'd0;
	localparam logic [1:0] PH_PLUS   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	logic [1:0]                       state_q;
	logic [1:0]                       phase_q;
	logic                             last_q;
	logic [2:0]                       mood_limit_q;
	logic [b32ts_pkg::TOKEN_W-1:0]    held_q;
	logic [b32ts_pkg::MIN_W-1:0]      minute_sum_q;
	logic [b32ts_pkg::DCNT_W-1:0]     digit_count_q;

	logic                             out_valid_q;
	logic                             found_q;
	logic [31:0]                      seed_q;
	logic [2:0]                       mood_q;
	logic [5:0]                       x_q;
	logic [5:0]                       y_q;
	logic [b32ts_pkg::MIN_W-1:0]      minutes_q;

	logic                             accept;
	logic [7:0]                       c_up;
	logic                             kept;
	logic                             is_digit;
	logic                             push;
	logic                             emit_go;
	logic                             chk_start;
	logic                             chk_done;
	logic [7:0]                       chk_acc;
	logic                             token_ok;
	logic [19:0]                      sum_x10;
	logic [b32ts_pkg::MIN_W-1:0]      sum_next;
	logic [b32ts_pkg::DCNT_W-1:0]     count_next;
	b32ts_pkg::win_status_t           win;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign c_up      = b32ts_pkg::fold_upper(character);
	assign kept      = b32ts_pkg::is_kept(c_up);
	assign is_digit  = (c_up >= 8'h30 && c_up <= 8'h39);
	assign push      = accept && kept && phase_q == PH_SEARCH;
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);
	assign chk_start = (state_q == ST_LOAD) && win.cand;
	assign token_ok  = chk_done && chk_acc == win.chk && win.payload[19:17] <= mood_limit_q;

	assign sum_x10    = {minute_sum_q, 3'b000} + {2'b00, minute_sum_q, 1'b0};
	assign sum_next   = b32ts_pkg::MIN_W'(sum_x10 + {16'd0, c_up[3:0]});
	assign count_next = digit_count_q + 1'b1;

	b32ts_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.clr    (emit_go),
		.ch     (c_up),
		.status (win)
	);

	b32ts_check u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (chk_start),
		.payload (win.payload),
		.done    (chk_done),
		.acc     (chk_acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mood_limit_q <= 3'd6;
		end else if (cfg_we) begin
			mood_limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= PH_SEARCH;
			last_q        <= 1'b0;
			minute_sum_q  <= '0;
			digit_count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= last;
						if (push) begin
							state_q <= ST_LOAD;
						end else begin
							if (kept) begin
								unique case (phase_q)
									PH_PLUS: begin
										phase_q <= (c_up == b32ts_pkg::CH_PLUS) ? PH_DIGITS : PH_DONE;
									end
									PH_DIGITS: begin
										if (is_digit &&
											digit_count_q < b32ts_pkg::DCNT_W'(b32ts_pkg::SUFFIX_DIGITS)) begin
											minute_sum_q  <= sum_next;
											digit_count_q <= count_next;
											if (count_next >= b32ts_pkg::DCNT_W'(b32ts_pkg::SUFFIX_DIGITS)) begin
												phase_q <= PH_DONE;
											end
										end else begin
											phase_q <= PH_DONE;
										end
									end
									default: begin
									end
								endcase
							end
							if (last) begin
								state_q <= ST_EMIT;
							end
						end
					end
				end
				ST_LOAD: begin
					if (win.cand) begin
						state_q <= ST_CHECK;
					end else begin
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_CHECK: begin
					if (chk_done) begin
						if (token_ok) begin
							phase_q <= PH_PLUS;
						end
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						phase_q       <= PH_SEARCH;
						minute_sum_q  <= '0;
						digit_count_q <= '0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// held token: {seed, mood, x, y} = payload bits 51..5
	always_ff @(posedge clk) begin
		if (token_ok) begin
			held_q <= win.payload[b32ts_pkg::PAY_W-1:5];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			found_q   <= (phase_q != PH_SEARCH);
			seed_q    <= (phase_q != PH_SEARCH) ? held_q[46:15] : 32'd0;
			mood_q    <= (phase_q != PH_SEARCH) ? held_q[14:12] : 3'd0;
			x_q       <= (phase_q != PH_SEARCH) ? held_q[11:6]  : 6'd0;
			y_q       <= (phase_q != PH_SEARCH) ? held_q[5:0]   : 6'd0;
			minutes_q <= minute_sum_q;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign seed      = seed_q;
	assign mood      = mood_q;
	assign x_code    = x_q;
	assign y_code    = y_q;
	assign minutes   = minutes_q;

	a_no_check_after_token: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> phase_q == PH_SEARCH)
		else $error("checksum running after token was found");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		digit_count_q <= b32ts_pkg::DCNT_W'(b32ts_pkg::SUFFIX_DIGITS))
		else $error("suffix digit count past limit");

	a_search_no_digits: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SEARCH |-> digit_count_q == '0 && minute_sum_q == '0)
		else $error("suffix state set while searching");

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
		else $error("result raised outside emit");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> seed_q == '0 && minutes_q == '0 && mood_q == '0)
		else $error("nonzero fields with no token");

endmodule
